// ===== sv/mcsr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsr_pkg
// Shared types and constants of the multi-channel slew ramp unit.
// ----------------------------------------------------------------------------
package mcsr_pkg;

   localparam int CH_W       = 6;
   localparam int POS_W      = 24;
   localparam int TGT_W      = 16;
   localparam int SPD_W      = 24;
   localparam int MS_W       = 16;
   localparam int PROD_W     = SPD_W + MS_W;
   localparam int DIV_IN_W   = 34;
   localparam int STEP_W     = 24;
   localparam int REM_W      = 10;
   localparam int KMUL_W     = POS_W + REM_W;
   localparam int DIV_SH_W   = 3;
   localparam int DIV_X_W    = DIV_IN_W - DIV_SH_W;
   localparam int RECIP_W    = 32;
   localparam int RECIP_SH   = 38;
   localparam int DIV_PROD_W = DIV_X_W + RECIP_W;

   localparam logic [REM_W:0]     MS_PER_SECOND = 11'd1000;
   localparam logic [RECIP_W-1:0] RECIP_125     = 32'd2199023256;

   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_ACTIVE   = 3'd1;
   localparam logic [2:0] ST_AT_TGT   = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_MOVED    = 3'd4;
   localparam logic [2:0] ST_ARRIVED  = 3'd5;
   localparam logic [2:0] ST_IDLE     = 3'd6;

   typedef struct packed {
      logic              shift;
      logic              take_head;
      logic              take_new;
      logic              live;
      logic [CH_W-1:0]   head_ch;
      logic [CH_W-1:0]   new_ch;
   } cell_ctl_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [TGT_W-1:0]  tgt;
      logic [SPD_W-1:0]  spd;
   } chan_rec_type;

endpackage

// ===== sv/mcsr_cell.sv =====
// ----------------------------------------------------------------------------
// mcsr_cell
// One slot of the active channel list; shifts toward the head, loads on append.
// ----------------------------------------------------------------------------
module mcsr_cell (
   input  logic                       clock,
   input  mcsr_pkg::cell_ctl_type     ctl,
   input  logic [mcsr_pkg::CH_W-1:0]  next_ch,
   output logic [mcsr_pkg::CH_W-1:0]  ch,
   output logic                       match
);
   import mcsr_pkg::*;

   logic [CH_W-1:0] ch_ff;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         ch_ff <= ctl.take_head ? ctl.head_ch : next_ch;
      end else if (ctl.take_new) begin
         ch_ff <= ctl.new_ch;
      end
   end

   assign ch    = ch_ff;
   assign match = ctl.live && (ch_ff == ctl.new_ch);

endmodule

// ===== sv/mcsr_div.sv =====
// ----------------------------------------------------------------------------
// mcsr_div
// Divide by 1000: drop three low bits, then multiply by the reciprocal of 125.
// ----------------------------------------------------------------------------
module mcsr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mcsr_pkg::DIV_IN_W-1:0] dividend,
   output logic                          done,
   output logic [mcsr_pkg::STEP_W-1:0]   quotient
);
   import mcsr_pkg::*;

   logic [DIV_X_W-1:0]    x_ff;
   logic                  x_vld_ff;
   logic                  done_ff;
   logic [STEP_W-1:0]     q_ff;
   logic [DIV_PROD_W-1:0] prod_in;

   assign prod_in = DIV_PROD_W'(x_ff) * DIV_PROD_W'(RECIP_125);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_vld_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         x_vld_ff <= start;
         done_ff  <= x_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) x_ff <= dividend[DIV_IN_W-1:DIV_SH_W];
      if (x_vld_ff) q_ff <= prod_in[RECIP_SH+STEP_W-1:RECIP_SH];
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== sv/multi_channel_slew_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// multi_channel_slew_ramp_unit
// Slew-rate limiter that ramps PWM channel positions toward their targets.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_stall   kind channel target speed delta_ms
//  rsp_      out        rsp_valid/rsp_stall   status chan_out pwm_value remaining last
//  csr_      in         csr_write_enable      csr_write_data (arrive threshold)
//
//  A start request reads the channel record and sets its status before output
//  wait; a tick with an empty list emits at once. Each listed channel of a tick
//  is clamped at its target or stepped by the reciprocal divide-by-1000 unit.
//  Reset clears the per-channel valid bits at once; no clearing pass is needed.
//  A stalled result holds the sequencer before it builds the next one.
// ----------------------------------------------------------------------------
module multi_channel_slew_ramp_unit #(
   parameter int NUM_CHANNELS = 64,
   parameter int MAX_ACTIVE   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_kind,
   input  logic [mcsr_pkg::CH_W-1:0]   req_channel,
   input  logic [mcsr_pkg::TGT_W-1:0]  req_target,
   input  logic [mcsr_pkg::SPD_W-1:0]  req_speed,
   input  logic [mcsr_pkg::MS_W-1:0]   req_delta_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_status,
   output logic [mcsr_pkg::CH_W-1:0]   rsp_chan_out,
   output logic [mcsr_pkg::TGT_W-1:0]  rsp_pwm_value,
   output logic [mcsr_pkg::POS_W-1:0]  rsp_remaining,
   output logic                        rsp_last,
   input  logic                        csr_write_enable,
   input  logic [15:0]                 csr_write_data
);
   import mcsr_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W = $clog2(MAX_ACTIVE + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SREAD, S_SCALC, S_TREAD, S_TMUL, S_TCMP, S_TDIV, S_TUPD, S_EMIT
   } state_type;

   function automatic logic [CH_W-1:0] chan_mod(input logic [CH_W-1:0] c);
      logic [CH_W-1:0] r;
      r = '0;
      for (int k = 0; k < (1 << CH_W); k++) begin
         if (c == CH_W'(k)) r = CH_W'(k % NUM_CHANNELS);
      end
      return r;
   endfunction

   state_type          state_ff;
   logic [15:0]        thr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   walk_ff;
   logic [CH_W-1:0]    cur_ch_ff;
   logic               kind_ff;
   logic [TGT_W-1:0]   tgt_ff;
   logic [SPD_W-1:0]   spd_ff;
   logic [MS_W-1:0]    ms_ff;

   chan_rec_type       mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] vld_ff;
   chan_rec_type       rd_ff;
   logic               rd_vld_ff;
   chan_rec_type       rec_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [KMUL_W-1:0]  dk_ff;
   logic               up_ff;
   logic [POS_W-1:0]   newpos_ff;

   logic [2:0]         res_status_ff;
   logic [TGT_W-1:0]   res_pwm_ff;
   logic [POS_W-1:0]   res_rem_ff;
   logic               res_last_ff;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [CH_W-1:0]    rsp_chan_ff;
   logic [TGT_W-1:0]   rsp_pwm_ff;
   logic [POS_W-1:0]   rsp_rem_ff;
   logic               rsp_last_ff;

   cell_ctl_type       ctl_in [MAX_ACTIVE];
   logic [CH_W-1:0]    cell_ch [MAX_ACTIVE];
   logic [MAX_ACTIVE-1:0] match;

   logic               div_start_in;
   logic               div_done;
   logic [STEP_W-1:0]  div_q;

   logic               accept_in;
   logic [IDX_W-1:0]   idx_in;
   logic               wr_en_in;
   chan_rec_type       wr_data_in;
   chan_rec_type       rd_rec_in;
   logic [POS_W-1:0]   s_tpos_in, s_dist_in, m_tpos_in, m_dist_in, u_tpos_in, u_dist_in;
   logic [TGT_W-1:0]   s_pwm_in, u_pwm_in;
   logic [2:0]         s_status_in;
   logic               u_keep_in;

   function automatic logic [POS_W-1:0] dist_of(input logic [POS_W-1:0] p,
                                                input logic [POS_W-1:0] t);
      return (p > t) ? (p - t) : (t - p);
   endfunction

   function automatic logic [TGT_W-1:0] pwm_of(input logic [POS_W-1:0] p);
      logic [POS_W:0] s;
      s = {1'b0, p} + (POS_W+1)'(128);
      return s[POS_W] ? '1 : s[POS_W-1:8];
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign accept_in = req_valid && !req_stall;
   assign idx_in    = IDX_W'(cur_ch_ff);

   always_comb begin
      rd_rec_in  = rd_vld_ff ? rd_ff : '0;
      s_tpos_in  = {tgt_ff, 8'b0};
      s_dist_in  = dist_of(rd_rec_in.pos, s_tpos_in);
      s_pwm_in   = pwm_of(rd_rec_in.pos);
      if (|match) begin
         s_status_in = ST_ACTIVE;
      end else if (s_dist_in < POS_W'(thr_ff)) begin
         s_status_in = ST_AT_TGT;
      end else if (count_ff >= CNT_W'(MAX_ACTIVE)) begin
         s_status_in = ST_FULL;
      end else begin
         s_status_in = ST_ADDED;
      end
      m_tpos_in = {rd_rec_in.tgt, 8'b0};
      m_dist_in = dist_of(rd_rec_in.pos, m_tpos_in);
      u_tpos_in = {rec_ff.tgt, 8'b0};
      u_dist_in = dist_of(newpos_ff, u_tpos_in);
      u_pwm_in  = pwm_of(newpos_ff);
      u_keep_in = !(u_dist_in < POS_W'(thr_ff));

      wr_en_in   = 1'b0;
      wr_data_in = rec_ff;
      if (state_ff == S_SCALC) begin
         wr_en_in   = 1'b1;
         wr_data_in = '{pos: rd_rec_in.pos, tgt: tgt_ff, spd: spd_ff};
      end else if (state_ff == S_TUPD) begin
         wr_en_in   = 1'b1;
         wr_data_in = '{pos: newpos_ff, tgt: rec_ff.tgt, spd: rec_ff.spd};
      end
      div_start_in = (state_ff == S_TCMP) && (prod_ff < PROD_W'(dk_ff));
   end

   always_comb begin
      for (int i = 0; i < MAX_ACTIVE; i++) begin
         ctl_in[i].shift     = (state_ff == S_TUPD);
         ctl_in[i].take_head = u_keep_in && (CNT_W'(i + 1) == count_ff);
         ctl_in[i].take_new  = (state_ff == S_SCALC) && (s_status_in == ST_ADDED)
                               && (CNT_W'(i) == count_ff);
         ctl_in[i].live      = (CNT_W'(i) < count_ff);
         ctl_in[i].head_ch   = cell_ch[0];
         ctl_in[i].new_ch    = cur_ch_ff;
      end
   end

   for (genvar g = 0; g < MAX_ACTIVE; g++) begin : g_cell
      mcsr_cell u_cell (
         .clock   (clock),
         .ctl     (ctl_in[g]),
         .next_ch ((g == MAX_ACTIVE - 1) ? cell_ch[0] : cell_ch[(g + 1) % MAX_ACTIVE]),
         .ch      (cell_ch[g]),
         .match   (match[g])
      );
   end

   mcsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_in),
      .dividend (prod_ff[DIV_IN_W-1:0]),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (wr_en_in) mem[idx_in] <= wr_data_in;
      rd_ff <= mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en_in) vld_ff[idx_in] <= 1'b1;
         rd_vld_ff <= vld_ff[idx_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 16'd128;
      end else if (csr_write_enable) begin
         thr_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_EMIT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept_in) begin
                  kind_ff <= req_kind;
                  tgt_ff  <= req_target;
                  spd_ff  <= req_speed;
                  ms_ff   <= req_delta_ms;
                  if (!req_kind) begin
                     cur_ch_ff <= chan_mod(req_channel);
                     walk_ff   <= '0;
                     state_ff  <= S_SREAD;
                  end else if (count_ff == '0) begin
                     cur_ch_ff     <= '0;
                     walk_ff       <= '0;
                     res_status_ff <= ST_IDLE;
                     res_pwm_ff    <= '0;
                     res_rem_ff    <= '0;
                     res_last_ff   <= 1'b1;
                     state_ff      <= S_EMIT;
                  end else begin
                     cur_ch_ff <= cell_ch[0];
                     walk_ff   <= count_ff;
                     state_ff  <= S_TREAD;
                  end
               end
            end
            S_SREAD: state_ff <= S_SCALC;
            S_SCALC: begin
               res_status_ff <= s_status_in;
               res_pwm_ff    <= s_pwm_in;
               res_rem_ff    <= s_dist_in;
               res_last_ff   <= 1'b1;
               if (s_status_in == ST_ADDED) count_ff <= count_ff + 1'b1;
               state_ff <= S_EMIT;
            end
            S_TREAD: state_ff <= S_TMUL;
            S_TMUL: begin
               rec_ff   <= rd_rec_in;
               prod_ff  <= rd_rec_in.spd * ms_ff;
               dk_ff    <= m_dist_in * KMUL_W'(MS_PER_SECOND);
               up_ff    <= (rd_rec_in.pos < m_tpos_in);
               state_ff <= S_TCMP;
            end
            S_TCMP: begin
               if (div_start_in) begin
                  state_ff <= S_TDIV;
               end else begin
                  newpos_ff <= {rec_ff.tgt, 8'b0};
                  state_ff  <= S_TUPD;
               end
            end
            S_TDIV: begin
               if (div_done) begin
                  newpos_ff <= up_ff ? rec_ff.pos + div_q : rec_ff.pos - div_q;
                  state_ff  <= S_TUPD;
               end
            end
            S_TUPD: begin
               res_status_ff <= u_keep_in ? ST_MOVED : ST_ARRIVED;
               res_pwm_ff    <= u_pwm_in;
               res_rem_ff    <= u_dist_in;
               res_last_ff   <= (walk_ff == CNT_W'(1));
               walk_ff       <= walk_ff - 1'b1;
               if (!u_keep_in) count_ff <= count_ff - 1'b1;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_chan_ff   <= cur_ch_ff;
                  rsp_pwm_ff    <= res_pwm_ff;
                  rsp_rem_ff    <= res_rem_ff;
                  rsp_last_ff   <= res_last_ff;
                  if (kind_ff && (walk_ff != '0)) begin
                     cur_ch_ff <= cell_ch[0];
                     state_ff  <= S_TREAD;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_chan_out  = rsp_chan_ff;
   assign rsp_pwm_value = rsp_pwm_ff;
   assign rsp_remaining = rsp_rem_ff;
   assign rsp_last      = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ACTIVE))
      else $error("active count above list size");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_TDIV)
      else $error("divider finished outside divide state");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("response raised outside emit state");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      walk_ff <= count_ff || state_ff == S_EMIT || state_ff == S_TUPD)
      else $error("walk counter beyond active count");

endmodule
